// ===== src/trs_pkg.sv =====
`timescale 1ns / 1ps

package trs_pkg;

   // Field widths fixed by the interface
   localparam int ID_W    = 8;
   localparam int SCORE_W = 32;
   localparam int GROUP_W = 5;

   // Default capacity of the candidate store
   localparam int MAX_CANDIDATES_DEFAULT = 32;

   // Depth of the queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // Class of an accepted item
   typedef enum logic {
      KIND_ENTRY,
      KIND_CLOSE
   } trs_kind_type;

   // One classified item as it travels through the queue
   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      trs_kind_type              kind;
   } trs_item_type;

   // True when entry a must be emitted before entry b
   function automatic logic goes_before(input logic signed [SCORE_W-1:0] sa,
                                        input logic [ID_W-1:0]           ia,
                                        input logic signed [SCORE_W-1:0] sb,
                                        input logic [ID_W-1:0]           ib,
                                        input logic                      desc);
      logic result;
      if (sa != sb) begin
         result = desc ? (sa > sb) : (sa < sb);
      end else begin
         result = (ia < ib);
      end
      return result;
   endfunction

endpackage

// ===== src/trs_front.sv =====
`timescale 1ns / 1ps

module trs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [trs_pkg::ID_W-1:0]           req_candidate_id,
   input  logic signed [trs_pkg::SCORE_W-1:0] req_score,
   input  logic                               req_last_item,
   input  logic                               queue_full,
   output logic                               push_valid,
   output trs_pkg::trs_item_type              push_item
);

   logic                  hold_valid_ff;
   logic                  hold_valid_in;
   trs_pkg::trs_item_type hold_item_ff;
   trs_pkg::trs_item_type hold_item_in;
   logic                  accept;
   logic                  push;

   // Stall only while the held item cannot move into the queue
   assign req_stall = hold_valid_ff & queue_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = hold_valid_ff & ~queue_full;

   // Classify the incoming transfer and hold it until the queue takes it
   always_comb begin
      hold_item_in  = hold_item_ff;
      hold_valid_in = hold_valid_ff & ~push;
      if (accept) begin
         hold_valid_in      = 1'b1;
         hold_item_in.id    = req_candidate_id;
         hold_item_in.score = req_score;
         hold_item_in.kind  = req_last_item ? trs_pkg::KIND_CLOSE : trs_pkg::KIND_ENTRY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

   assign push_valid = push;
   assign push_item  = hold_item_ff;

endmodule

// ===== src/trs_queue.sv =====
`timescale 1ns / 1ps

module trs_queue #(
   parameter int DEPTH = trs_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  trs_pkg::trs_item_type push_item,
   input  logic                  pop,
   output trs_pkg::trs_item_type pop_item,
   output logic                  full,
   output logic                  nonempty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   trs_pkg::trs_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/trs_back.sv =====
`timescale 1ns / 1ps

module trs_back #(
   parameter int MAX_CANDIDATES = trs_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               order_descending,
   input  logic                               queue_nonempty,
   input  trs_pkg::trs_item_type              queue_item,
   output logic                               queue_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [trs_pkg::ID_W-1:0]           rsp_out_candidate,
   output logic signed [trs_pkg::SCORE_W-1:0] rsp_out_score,
   output logic [trs_pkg::GROUP_W-1:0]        rsp_group_index,
   output logic                               rsp_group_end,
   output logic                               rsp_final_result
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic [CNT_W-1:0]                   round_ff;
   logic [CNT_W-1:0]                   round_in;
   logic                               phase_ff;
   logic                               phase_in;
   logic [trs_pkg::GROUP_W-1:0]        grp_ff;
   logic [trs_pkg::GROUP_W-1:0]        grp_in;
   logic signed [trs_pkg::SCORE_W-1:0] score_ff [MAX_CANDIDATES];
   logic signed [trs_pkg::SCORE_W-1:0] score_in [MAX_CANDIDATES];
   logic [trs_pkg::ID_W-1:0]           id_ff [MAX_CANDIDATES];
   logic [trs_pkg::ID_W-1:0]           id_in [MAX_CANDIDATES];
   logic [MAX_CANDIDATES-1:0]          match;
   logic                               found;
   logic [MAX_CANDIDATES-2:0]          swap;
   logic                               out_free;
   logic                               emit;
   logic                               head_group_end;
   logic                               head_final;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [trs_pkg::ID_W-1:0]           rsp_id_ff;
   logic signed [trs_pkg::SCORE_W-1:0] rsp_score_ff;
   logic [trs_pkg::GROUP_W-1:0]        rsp_grp_ff;
   logic                               rsp_gend_ff;
   logic                               rsp_final_ff;

   // Compare the loading id against every occupied cell
   always_comb begin
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (id_ff[i] == queue_item.id);
      end
   end
   assign found = |match;

   // Compare-exchange on the pairs of the current phase
   always_comb begin
      for (int i = 0; i < MAX_CANDIDATES - 1; i++) begin
         swap[i] = (1'(i % 2) == phase_ff) && (CNT_W'(i + 1) < count_ff) &&
                   trs_pkg::goes_before(score_ff[i + 1], id_ff[i + 1],
                                        score_ff[i], id_ff[i], order_descending);
      end
   end

   assign out_free       = ~rsp_valid_ff | ~rsp_stall;
   assign emit           = (state_ff == ST_EMIT) & out_free;
   assign queue_pop      = (state_ff == ST_LOAD) & queue_nonempty;
   assign head_final     = (count_ff == CNT_W'(1));
   assign head_group_end = head_final | (score_ff[0] != score_ff[1]);
   assign rsp_valid_in   = emit | (rsp_valid_ff & rsp_stall);

   // Sequence load, sort rounds and shift-out emission
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      phase_in = phase_ff;
      grp_in   = grp_ff;
      score_in = score_ff;
      id_in    = id_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (queue_pop) begin
               for (int i = 0; i < MAX_CANDIDATES; i++) begin
                  if (match[i]) begin
                     score_in[i] = queue_item.score;
                  end else if (!found && CNT_W'(i) == count_ff) begin
                     score_in[i] = queue_item.score;
                     id_in[i]    = queue_item.id;
                  end
               end
               if (!found && count_ff < CNT_W'(MAX_CANDIDATES)) begin
                  count_in = count_ff + 1'b1;
               end
               if (queue_item.kind == trs_pkg::KIND_CLOSE) begin
                  state_in = ST_SORT;
                  round_in = '0;
                  phase_in = 1'b0;
               end
            end
         end
         ST_SORT: begin
            for (int i = 0; i < MAX_CANDIDATES - 1; i++) begin
               if (swap[i]) begin
                  score_in[i]     = score_ff[i + 1];
                  id_in[i]        = id_ff[i + 1];
                  score_in[i + 1] = score_ff[i];
                  id_in[i + 1]    = id_ff[i];
               end
            end
            phase_in = ~phase_ff;
            round_in = round_ff + 1'b1;
            if (round_ff == count_ff - 1'b1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               for (int i = 0; i < MAX_CANDIDATES - 1; i++) begin
                  score_in[i] = score_ff[i + 1];
                  id_in[i]    = id_ff[i + 1];
               end
               count_in = count_ff - 1'b1;
               if (head_group_end) begin
                  grp_in = grp_ff + 1'b1;
               end
               if (head_final) begin
                  state_in = ST_LOAD;
                  grp_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Hold state, cells and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         round_ff     <= '0;
         phase_ff     <= 1'b0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         phase_ff     <= phase_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      score_ff <= score_in;
      id_ff    <= id_in;
      if (emit) begin
         rsp_id_ff    <= id_ff[0];
         rsp_score_ff <= score_ff[0];
         rsp_grp_ff   <= grp_ff;
         rsp_gend_ff  <= head_group_end;
         rsp_final_ff <= head_final;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_candidate = rsp_id_ff;
   assign rsp_out_score     = rsp_score_ff;
   assign rsp_group_index   = rsp_grp_ff;
   assign rsp_group_end     = rsp_gend_ff;
   assign rsp_final_result  = rsp_final_ff;

endmodule

// ===== src/tie_grouping_rank_sorter_core.sv =====
`timescale 1ns / 1ps

// Ranks a set of candidates by score and emits them in dense rank groups.
// Request channel (req_): one candidate per transfer, an id and a signed score;
// req_last_item closes the set. A repeated id overwrites its stored score, and
// a new id past capacity is dropped. Response channel (rsp_): one transfer per
// stored candidate, groups in score order (ascending, or descending when the
// csr_ register is 1), ids ascending within a group, with the group index,
// a group-end flag and a flag on the final result.
// Throughput: the load unit takes one candidate per cycle while in its load
// state. The closing item starts an odd-even transposition sort of n rounds
// over the cell row, then emission shifts the row out at one result per cycle.
// The closing transfer passes the input register, the queue, the load, n sort
// rounds and the output register before the first result is valid. A two-entry
// queue between the input stage and the sorter lets requests arrive while a set
// is sorted or emitted; req_stall rises when it is full and an item is held.
// When the receiver stalls, the output register holds its result and
// emission pauses. Synchronous reset empties the store and the queue and
// clears the order register to ascending.
module tie_grouping_rank_sorter_core #(
   parameter int MAX_CANDIDATES = trs_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [trs_pkg::ID_W-1:0]           req_candidate_id,
   input  logic signed [trs_pkg::SCORE_W-1:0] req_score,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [trs_pkg::ID_W-1:0]           rsp_out_candidate,
   output logic signed [trs_pkg::SCORE_W-1:0] rsp_out_score,
   output logic [trs_pkg::GROUP_W-1:0]        rsp_group_index,
   output logic                               rsp_group_end,
   output logic                               rsp_final_result,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_order_descending
);

   logic                  order_descending_ff;
   logic                  push_valid;
   trs_pkg::trs_item_type push_item;
   logic                  queue_full;
   logic                  queue_nonempty;
   logic                  queue_pop;
   trs_pkg::trs_item_type queue_item;

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_descending_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         order_descending_ff <= csr_order_descending;
      end
   end

   trs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_candidate_id (req_candidate_id),
      .req_score        (req_score),
      .req_last_item    (req_last_item),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   trs_queue #(
      .DEPTH (trs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .full      (queue_full),
      .nonempty  (queue_nonempty)
   );

   trs_back #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .order_descending  (order_descending_ff),
      .queue_nonempty    (queue_nonempty),
      .queue_item        (queue_item),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_candidate (rsp_out_candidate),
      .rsp_out_score     (rsp_out_score),
      .rsp_group_index   (rsp_group_index),
      .rsp_group_end     (rsp_group_end),
      .rsp_final_result  (rsp_final_result)
   );

endmodule
